// ----- rtl/core/crcfr_pkg.sv -----
package crcfr_pkg;

	// Default frame body limit and result queue depth
	localparam int BODY_BYTES_DEF  = 512;
	localparam int QUEUE_DEPTH_DEF = 4;

	localparam logic [7:0]  START_BYTE = 8'h1B;
	localparam logic [7:0]  TOKEN_BYTE = 8'h0E;
	localparam logic [15:0] CRC_INIT   = 16'hFFFF;
	localparam logic [15:0] CRC_POLY   = 16'h8408;

	// Header byte positions: sequence low/high, length bytes, then token
	localparam logic [2:0] HDR_LEN_FIRST = 3'd2;
	localparam logic [2:0] HDR_TOKEN     = 3'd6;

	typedef enum logic [1:0] {
		PH_HUNT,
		PH_HEADER,
		PH_BODY,
		PH_CRC
	} phase_t;

	typedef enum logic [1:0] {
		ST_GOOD,
		ST_TOKEN,
		ST_LENGTH,
		ST_CRC
	} status_t;

	typedef enum logic {
		KIND_BODY,
		KIND_END
	} kind_t;

	typedef struct packed {
		kind_t       kind;
		logic [7:0]  body_byte;
		logic [8:0]  byte_index;
		logic [15:0] seq_number;
		logic [9:0]  body_length;
		status_t     status;
	} result_t;

	// Reflected CCITT CRC-16 update over one byte, LSB first
	function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {8'h00, b};
		for (int k = 0; k < 8; k++) begin
			if (c[0]) begin
				c = (c >> 1) ^ CRC_POLY;
			end else begin
				c = c >> 1;
			end
		end
		return c;
	endfunction

endpackage

// ----- rtl/core/crcfr_parse.sv -----
module crcfr_parse #(
	parameter int BODY_BYTES = crcfr_pkg::BODY_BYTES_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               accept,
	input  logic [7:0]         rx_byte,
	output logic               res_valid,
	output crcfr_pkg::result_t res
);
	import crcfr_pkg::*;

	localparam int CntW = $clog2(BODY_BYTES + 1);

	phase_t          phase_q, phase_d;
	logic [2:0]      hdr_q, hdr_d;
	logic [15:0]     seq_q, seq_d;
	logic [31:0]     len_q, len_d;
	logic [CntW-1:0] cnt_q, cnt_d;
	logic [15:0]     crc_q, crc_d;

	logic [15:0]     crc_new;
	logic [15:0]     crc_first;
	logic            too_long;
	logic [CntW:0]   cnt_inc;
	logic [1:0]      len_sel;

	assign crc_new   = crc_byte(crc_q, rx_byte);
	assign crc_first = crc_byte(CRC_INIT, rx_byte);
	assign too_long  = len_q > 32'(BODY_BYTES);
	assign cnt_inc   = {1'b0, cnt_q} + {{CntW{1'b0}}, 1'b1};
	assign len_sel   = 2'(hdr_q - HDR_LEN_FIRST);

	// Next state
	always_comb begin
		phase_d = phase_q;
		hdr_d   = hdr_q;
		seq_d   = seq_q;
		len_d   = len_q;
		cnt_d   = cnt_q;
		crc_d   = crc_q;
		if (accept) begin
			unique case (phase_q)
				PH_HUNT: begin
					if (rx_byte == START_BYTE) begin
						crc_d   = crc_first;
						hdr_d   = '0;
						seq_d   = '0;
						len_d   = '0;
						cnt_d   = '0;
						phase_d = PH_HEADER;
					end
				end
				PH_HEADER: begin
					crc_d = crc_new;
					if (hdr_q < HDR_LEN_FIRST) begin
						if (hdr_q[0]) begin
							seq_d[15:8] = rx_byte;
						end else begin
							seq_d[7:0] = rx_byte;
						end
						hdr_d = hdr_q + 3'd1;
					end else if (hdr_q < HDR_TOKEN) begin
						len_d[{len_sel, 3'b000} +: 8] = rx_byte;
						hdr_d = hdr_q + 3'd1;
					end else if (rx_byte != TOKEN_BYTE || too_long) begin
						phase_d = PH_HUNT;
					end else begin
						cnt_d   = '0;
						hdr_d   = '0;
						phase_d = (len_q == '0) ? PH_CRC : PH_BODY;
					end
				end
				PH_BODY: begin
					crc_d = crc_new;
					cnt_d = cnt_inc[CntW-1:0];
					if (cnt_inc >= {1'b0, len_q[CntW-1:0]}) begin
						hdr_d   = '0;
						phase_d = PH_CRC;
					end
				end
				PH_CRC: begin
					crc_d = crc_new;
					hdr_d = hdr_q + 3'd1;
					if (hdr_q != '0) begin
						phase_d = PH_HUNT;
					end
				end
				default: phase_d = PH_HUNT;
			endcase
		end
	end

	// Result word
	always_comb begin
		res_valid       = 1'b0;
		res.kind        = KIND_BODY;
		res.body_byte   = '0;
		res.byte_index  = '0;
		res.seq_number  = seq_q;
		res.body_length = too_long ? 10'd0 : len_q[9:0];
		res.status      = ST_GOOD;
		if (accept) begin
			unique case (phase_q)
				PH_HUNT: res_valid = 1'b0;
				PH_HEADER: begin
					if (hdr_q == HDR_TOKEN) begin
						if (rx_byte != TOKEN_BYTE) begin
							res_valid  = 1'b1;
							res.kind   = KIND_END;
							res.status = ST_TOKEN;
						end else if (too_long) begin
							res_valid  = 1'b1;
							res.kind   = KIND_END;
							res.status = ST_LENGTH;
						end
					end
				end
				PH_BODY: begin
					res_valid      = 1'b1;
					res.body_byte  = rx_byte;
					res.byte_index = 9'(cnt_q);
				end
				PH_CRC: begin
					if (hdr_q != '0) begin
						res_valid  = 1'b1;
						res.kind   = KIND_END;
						res.status = (crc_new == '0) ? ST_GOOD : ST_CRC;
					end
				end
				default: res_valid = 1'b0;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HUNT;
			hdr_q   <= '0;
			seq_q   <= '0;
			len_q   <= '0;
			cnt_q   <= '0;
			crc_q   <= CRC_INIT;
		end else begin
			phase_q <= phase_d;
			hdr_q   <= hdr_d;
			seq_q   <= seq_d;
			len_q   <= len_d;
			cnt_q   <= cnt_d;
			crc_q   <= crc_d;
		end
	end

	a_body_len_ok: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_BODY |-> (len_q != '0 && len_q <= 32'(BODY_BYTES)))
		else $error("body phase with bad length");

	a_crc_count: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_CRC |-> hdr_q <= 3'd1)
		else $error("crc byte count out of range");

	a_end_hunts: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && res.kind == KIND_END) |=> phase_q == PH_HUNT)
		else $error("frame end did not return to hunting");

	a_hdr_range: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_HEADER |-> hdr_q <= HDR_TOKEN)
		else $error("header count out of range");

endmodule

// ----- rtl/core/crcfr_queue.sv -----
module crcfr_queue #(
	parameter int DEPTH = crcfr_pkg::QUEUE_DEPTH_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  crcfr_pkg::result_t wdata,
	output logic               full,
	output logic               empty,
	input  logic               pop,
	output crcfr_pkg::result_t rdata
);
	import crcfr_pkg::*;

	localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CntW = $clog2(DEPTH + 1);

	result_t         mem [DEPTH];
	logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CntW-1:0] count_q;
	logic            wr_en, rd_en;

	assign full  = count_q == CntW'(DEPTH);
	assign empty = count_q == '0;
	assign wr_en = push && !full;
	assign rd_en = pop && !empty;
	assign rdata = mem[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_q + PtrW'(1);
			end
			if (rd_en) begin
				rd_ptr_q <= (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_q + PtrW'(1);
			end
			if (wr_en && !rd_en) begin
				count_q <= count_q + CntW'(1);
			end else if (rd_en && !wr_en) begin
				count_q <= count_q - CntW'(1);
			end
		end
	end

	a_count_max: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CntW'(DEPTH))
		else $error("queue count beyond depth");

	a_count_up: assert property (@(posedge clk) disable iff (!arst_n)
		(wr_en && !rd_en) |=> count_q == $past(count_q) + CntW'(1))
		else $error("queue count missed a write");

	a_count_down: assert property (@(posedge clk) disable iff (!arst_n)
		(rd_en && !wr_en) |=> count_q == $past(count_q) - CntW'(1))
		else $error("queue count missed a read");

endmodule

// ----- rtl/core/crc_checked_frame_receiver.sv -----
// Channel   Direction  Handshake             Word
// input     in         push / full           rx_byte
// result    out        empty / pop           kind, body_byte, byte_index, seq_number,
//                                            body_length, status
//
// One received byte is taken per cycle while full is low; its frame parse and CRC
// update finish in that same cycle and any result word lands in the result queue
// at the next edge.
// Reset (arst_n low) returns the parser to hunting and empties the queue.
// full rises only when the result queue holds QUEUE_DEPTH words; the result side
// stalls freely and the input side keeps going until that queue fills.
module crc_checked_frame_receiver #(
	parameter int BODY_BYTES  = crcfr_pkg::BODY_BYTES_DEF,
	parameter int QUEUE_DEPTH = crcfr_pkg::QUEUE_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [7:0]  rx_byte,
	output logic        empty,
	input  logic        pop,
	output logic        kind,
	output logic [7:0]  body_byte,
	output logic [8:0]  byte_index,
	output logic [15:0] seq_number,
	output logic [9:0]  body_length,
	output logic [1:0]  status
);
	import crcfr_pkg::*;

	logic    accept;
	logic    res_valid;
	result_t res;
	result_t head;

	// Take a byte only when the queue has room for whatever it may produce
	assign accept = push && !full;

	// Front: hunt for the start byte, collect header, check CRC, classify each byte
	crcfr_parse #(
		.BODY_BYTES(BODY_BYTES)
	) u_parse (
		.clk      (clk),
		.arst_n   (arst_n),
		.accept   (accept),
		.rx_byte  (rx_byte),
		.res_valid(res_valid),
		.res      (res)
	);

	// Back: hold result words until the consumer pops them
	crcfr_queue #(
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (res_valid),
		.wdata (res),
		.full  (full),
		.empty (empty),
		.pop   (pop),
		.rdata (head)
	);

	// Drive the oldest waiting word onto the result ports
	assign kind        = head.kind;
	assign body_byte   = head.body_byte;
	assign byte_index  = head.byte_index;
	assign seq_number  = head.seq_number;
	assign body_length = head.body_length;
	assign status      = head.status;

	a_no_drop: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> !full)
		else $error("result produced while queue full");

	a_push_fills: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && !pop) |=> !empty)
		else $error("result word lost on its way into the queue");

	a_full_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(full && !pop) |=> full)
		else $error("queue drained without a pop");

endmodule
